// ===== rtl/core/sms_pkg.sv =====
package sms_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam logic [2:0] ACT_INSERT     = 3'd0;
    localparam logic [2:0] ACT_DELETE_ONE = 3'd1;
    localparam logic [2:0] ACT_DELETE_ALL = 3'd2;
    localparam logic [2:0] ACT_QUERY      = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]       t_count;

    // start opens a new tally; vld marks one entry of the resulting table
    typedef struct packed {
        logic   start;
        logic   vld;
        t_value data;
    } t_emit;

endpackage

// ===== rtl/core/sms_ram.sv =====
module sms_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sms_tally.sv =====
module sms_tally (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sms_pkg::t_emit        i_emit,
    input  sms_pkg::t_value       i_value,
    output sms_pkg::t_count       o_value_count,
    output sms_pkg::t_count       o_distinct_count
);

    sms_pkg::t_count r_vc;
    sms_pkg::t_count r_dc;
    sms_pkg::t_value r_prev;
    logic            r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (i_emit.start) begin
            r_first <= 1'b1;
        end else if (i_emit.vld) begin
            r_first <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.start) begin
            r_vc <= '0;
            r_dc <= '0;
        end else if (i_emit.vld) begin
            if (i_emit.data == i_value) begin
                r_vc <= r_vc + sms_pkg::CNT_W'(1);
            end
            if (r_first || (i_emit.data != r_prev)) begin
                r_dc <= r_dc + sms_pkg::CNT_W'(1);
            end
            r_prev <= i_emit.data;
        end
    end

    assign o_value_count    = r_vc;
    assign o_distinct_count = r_dc;

endmodule

// ===== rtl/core/sorted_multiset_table_unit.sv =====
// An accepted item walks the filled entries in S_SCAN, one entry read per cycle;
// an insert with room then writes its last entry in S_TAIL, and S_DONE loads the
// output register once it is empty or taken. Clear or a non-insert on an empty
// table goes right to S_DONE, an insert into an empty table via S_TAIL. One item
// at a time: the input stalls until the result of that item is loaded.
// Reset: synchronous, active low; empties the table and drops any result.
module sorted_multiset_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_value_count,
    output logic        o_present,
    output logic [6:0]  o_total_count,
    output logic [6:0]  o_distinct_count,
    output logic [1:0]  o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int IW = sms_pkg::IDX_W;
    localparam int CW = sms_pkg::CNT_W;

    logic [1:0]      r_state, n_state;
    logic [2:0]      r_act, n_act;
    sms_pkg::t_value r_val, n_val;
    logic [IW-1:0]   r_idx, n_idx;
    sms_pkg::t_count r_wr, n_wr;
    sms_pkg::t_count r_fill, n_fill;
    logic            r_ins, n_ins;
    logic            r_found, n_found;
    sms_pkg::t_value r_carry, n_carry;
    logic [1:0]      r_status, n_status;

    logic            r_o_valid;
    sms_pkg::t_count r_o_vc, r_o_tc, r_o_dc;
    logic [1:0]      r_o_st;

    sms_pkg::t_emit  emit;
    logic            we;
    logic [IW-1:0]   waddr, raddr;
    sms_pkg::t_value rdata, v_in;
    sms_pkg::t_count vc, dc;
    logic            in_xfer, last, load_out;

    assign v_in    = i_value[sms_pkg::VALUE_WIDTH-1:0];
    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign last    = ((CW'(r_idx) + CW'(1)) == r_fill);
    assign load_out = (r_state == S_DONE) && (!r_o_valid || !i_stall);

    sms_ram #(
        .DEPTH(sms_pkg::CAPACITY),
        .WIDTH(sms_pkg::VALUE_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (emit.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sms_tally u_tally (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_emit           (emit),
        .i_value          (r_val),
        .o_value_count    (vc),
        .o_distinct_count (dc)
    );

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_val    = r_val;
        n_idx    = r_idx;
        n_wr     = r_wr;
        n_fill   = r_fill;
        n_ins    = r_ins;
        n_found  = r_found;
        n_carry  = r_carry;
        n_status = r_status;
        emit     = '0;
        we       = 1'b0;
        waddr    = r_idx;
        raddr    = r_idx + IW'(1);

        case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (in_xfer) begin
                    emit.start = 1'b1;
                    n_val      = v_in;
                    n_idx      = '0;
                    n_wr       = '0;
                    n_ins      = 1'b0;
                    n_found    = 1'b0;
                    n_status   = sms_pkg::ST_OK;
                    n_act      = i_action;
                    if (i_action == sms_pkg::ACT_INSERT &&
                        r_fill == CW'(sms_pkg::CAPACITY)) begin
                        n_act    = sms_pkg::ACT_QUERY;
                        n_status = sms_pkg::ST_FULL;
                    end else if (i_action != sms_pkg::ACT_INSERT &&
                                 i_action != sms_pkg::ACT_DELETE_ONE &&
                                 i_action != sms_pkg::ACT_DELETE_ALL &&
                                 i_action != sms_pkg::ACT_CLEAR) begin
                        n_act = sms_pkg::ACT_QUERY;
                    end
                    if (i_action == sms_pkg::ACT_CLEAR) begin
                        n_fill  = '0;
                        n_state = S_DONE;
                    end else if (r_fill == '0) begin
                        n_state = (i_action == sms_pkg::ACT_INSERT) ? S_TAIL : S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                emit.vld  = 1'b1;
                emit.data = rdata;
                case (r_act)
                    sms_pkg::ACT_INSERT: begin
                        we = 1'b1;
                        if (r_ins) begin
                            emit.data = r_carry;
                            n_carry   = rdata;
                        end else if (rdata > r_val) begin
                            emit.data = r_val;
                            n_carry   = rdata;
                            n_ins     = 1'b1;
                        end
                    end
                    sms_pkg::ACT_DELETE_ONE: begin
                        waddr = r_wr[IW-1:0];
                        if (!r_found && rdata == r_val) begin
                            emit.vld = 1'b0;
                            n_found  = 1'b1;
                        end
                    end
                    sms_pkg::ACT_DELETE_ALL: begin
                        waddr = r_wr[IW-1:0];
                        if (rdata == r_val) begin
                            emit.vld = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_act == sms_pkg::ACT_DELETE_ONE ||
                    r_act == sms_pkg::ACT_DELETE_ALL) begin
                    we   = emit.vld;
                    n_wr = r_wr + CW'(emit.vld);
                end
                n_idx = r_idx + IW'(1);
                if (last) begin
                    if (r_act == sms_pkg::ACT_INSERT) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_DONE;
                        if (r_act == sms_pkg::ACT_DELETE_ONE ||
                            r_act == sms_pkg::ACT_DELETE_ALL) begin
                            n_fill = n_wr;
                        end
                    end
                end
            end
            S_TAIL: begin
                emit.vld  = 1'b1;
                emit.data = r_ins ? r_carry : r_val;
                we        = 1'b1;
                waddr     = r_fill[IW-1:0];
                n_fill    = r_fill + CW'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (r_act == sms_pkg::ACT_DELETE_ONE && !r_found) begin
                    n_status = sms_pkg::ST_NOT_FOUND;
                end
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_ins    <= n_ins;
        r_found  <= n_found;
        r_carry  <= n_carry;
        r_status <= n_status;
        if (load_out) begin
            r_o_vc <= vc;
            r_o_tc <= r_fill;
            r_o_dc <= dc;
            r_o_st <= (r_act == sms_pkg::ACT_DELETE_ONE && !r_found) ?
                      sms_pkg::ST_NOT_FOUND : r_status;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_value_count    = r_o_vc;
    assign o_present        = (r_o_vc != '0);
    assign o_total_count    = r_o_tc;
    assign o_distinct_count = r_o_dc;
    assign o_status         = r_o_st;

endmodule

// ===== rtl/core/sms_chk.sv =====
module sms_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [2:0]  i_action,
    input logic [31:0] i_value,
    input logic        o_valid,
    input logic        i_stall,
    input logic [6:0]  o_value_count,
    input logic        o_present,
    input logic [6:0]  o_total_count,
    input logic [6:0]  o_distinct_count,
    input logic [1:0]  o_status
);

    // one item in flight: a transfer closes the input until its result is built
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while an item is in flight");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distinct_count <= o_total_count) &&
                    (o_value_count <= o_total_count) &&
                    (o_total_count <= 7'(sms_pkg::CAPACITY)))
        else $error("result counts inconsistent");

    a_present_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_present |-> (o_distinct_count != 7'd0))
        else $error("value present in a table with no distinct values");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == sms_pkg::ST_FULL) |->
            (o_total_count == 7'(sms_pkg::CAPACITY)))
        else $error("full status reported on a table with room");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value_count) &&
            $stable(o_total_count) && $stable(o_distinct_count) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind sorted_multiset_table_unit sms_chk u_sms_chk (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic [2:0] ACT_UNUSED_FIRST = sms_pkg::ACT_CLEAR + 3'd1;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 830;
    localparam int CALM_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_ITEMS   = 40;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 100;

    typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} t_mode;

    typedef struct packed {
        sms_pkg::t_count value_count;
        logic            present;
        sms_pkg::t_count total_count;
        sms_pkg::t_count distinct_count;
        logic [1:0]      status;
    } t_tally;

    class multiset_mirror;
        sms_pkg::t_value held[sms_pkg::CAPACITY];
        int     fill;
        t_tally pending_tallies[$];
        int     errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_tallies.size();
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // apply one accepted request to the mirror table and queue its tally
        function void accept_transfer(logic [2:0] act, sms_pkg::t_value val);
            t_tally t;
            int     pos;
            int     w;
            int     i;
            int     n;
            int     d;
            t.status = sms_pkg::ST_OK;
            case (act)
                sms_pkg::ACT_INSERT: begin
                    if (fill >= sms_pkg::CAPACITY) begin
                        t.status = sms_pkg::ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < fill && held[pos] <= val) pos++;
                        for (i = fill; i > pos; i--) held[i] = held[i-1];
                        held[pos] = val;
                        fill++;
                    end
                end
                sms_pkg::ACT_DELETE_ONE: begin
                    pos = 0;
                    while (pos < fill && held[pos] != val) pos++;
                    if (pos < fill) begin
                        for (i = pos; i + 1 < fill; i++) held[i] = held[i+1];
                        fill--;
                    end else begin
                        t.status = sms_pkg::ST_NOT_FOUND;
                    end
                end
                sms_pkg::ACT_DELETE_ALL: begin
                    w = 0;
                    for (i = 0; i < fill; i++)
                        if (held[i] != val) begin
                            held[w] = held[i];
                            w++;
                        end
                    fill = w;
                end
                sms_pkg::ACT_CLEAR: fill = 0;
                default: ;
            endcase
            n = 0;
            d = 0;
            for (i = 0; i < fill; i++) begin
                if (held[i] == val) n++;
                if (i == 0 || held[i] != held[i-1]) d++;
            end
            t.value_count    = sms_pkg::t_count'(n);
            t.present        = (n != 0);
            t.total_count    = sms_pkg::t_count'(fill);
            t.distinct_count = sms_pkg::t_count'(d);
            pending_tallies.push_back(t);
        endfunction

        task check_tally(t_tally got);
            t_tally want;
            if (pending_tallies.size() == 0) begin
                flag_mismatch("result transfer with nothing outstanding");
                return;
            end
            want = pending_tallies.pop_front();
            if (got.value_count !== want.value_count)
                flag_mismatch($sformatf("value_count %0d, want %0d",
                                        got.value_count, want.value_count));
            if (got.present !== want.present)
                flag_mismatch($sformatf("present %0b, want %0b",
                                        got.present, want.present));
            if (got.total_count !== want.total_count)
                flag_mismatch($sformatf("total_count %0d, want %0d",
                                        got.total_count, want.total_count));
            if (got.distinct_count !== want.distinct_count)
                flag_mismatch($sformatf("distinct_count %0d, want %0d",
                                        got.distinct_count, want.distinct_count));
            if (got.status !== want.status)
                flag_mismatch($sformatf("status %0d, want %0d",
                                        got.status, want.status));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_action;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic [6:0]  o_value_count;
    logic        o_present;
    logic [6:0]  o_total_count;
    logic [6:0]  o_distinct_count;
    logic [1:0]  o_status;

    bit calm        = 1'b0;
    bit hold_wanted = 1'b0;

    multiset_mirror mirror = new();

    sorted_multiset_table_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value_count    (o_value_count),
        .o_present        (o_present),
        .o_total_count    (o_total_count),
        .o_distinct_count (o_distinct_count),
        .o_status         (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            mirror.check_tally({o_value_count, o_present, o_total_count,
                                o_distinct_count, o_status});
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        i_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [2:0] act, input sms_pkg::t_value val,
                             input bit may_idle);
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= val;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        mirror.accept_transfer(act, val);
        if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    function automatic sms_pkg::t_value fresh_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return sms_pkg::t_value'($urandom_range(0, 3));
            default: return sms_pkg::t_value'($urandom());
        endcase
    endfunction

    function automatic logic [2:0] pick_action(t_mode mode);
        int r;
        int t_ins;
        int t_del;
        int t_all;
        int t_qry;
        int t_clr;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  begin t_ins = 88; t_del = 93; t_all = 95; t_qry = 98; t_clr = 99; end
            MODE_DRAIN: begin t_ins = 15; t_del = 60; t_all = 75; t_qry = 92; t_clr = 94; end
            default:    begin t_ins = 45; t_del = 70; t_all = 78; t_qry = 92; t_clr = 95; end
        endcase
        if (r < t_ins) return sms_pkg::ACT_INSERT;
        if (r < t_del) return sms_pkg::ACT_DELETE_ONE;
        if (r < t_all) return sms_pkg::ACT_DELETE_ALL;
        if (r < t_qry) return sms_pkg::ACT_QUERY;
        if (r < t_clr) return sms_pkg::ACT_CLEAR;
        return 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
    endfunction

    initial begin
        int              done;
        int              blk;
        int              blk_len;
        int              pool_n;
        int              k;
        t_mode           mode;
        sms_pkg::t_value pool[12];
        sms_pkg::t_value val;

        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_action <= sms_pkg::ACT_QUERY;
        i_value  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, absent values, spare codes, clear
        send_item(sms_pkg::ACT_DELETE_ONE, 32'h0000_0005, 1'b1);
        send_item(sms_pkg::ACT_DELETE_ALL, 32'h0000_0005, 1'b1);
        send_item(sms_pkg::ACT_QUERY,      32'h0000_0000, 1'b1);
        send_item(sms_pkg::ACT_INSERT,     32'hFFFF_FFFF, 1'b1);
        send_item(sms_pkg::ACT_INSERT,     32'h0000_0000, 1'b1);
        send_item(sms_pkg::ACT_INSERT,     32'h0000_0000, 1'b1);
        send_item(sms_pkg::ACT_INSERT,     32'h8000_0000, 1'b1);
        send_item(sms_pkg::ACT_INSERT,     32'h7FFF_FFFF, 1'b1);
        send_item(sms_pkg::ACT_INSERT,     32'hFFFF_FFFF, 1'b1);
        send_item(sms_pkg::ACT_QUERY,      32'h0000_0000, 1'b1);
        send_item(sms_pkg::ACT_QUERY,      32'hFFFF_FFFF, 1'b1);
        send_item(sms_pkg::ACT_DELETE_ONE, 32'h1234_5678, 1'b1);
        send_item(sms_pkg::ACT_DELETE_ALL, 32'h1234_5678, 1'b1);
        send_item(sms_pkg::ACT_DELETE_ONE, 32'h0000_0000, 1'b1);
        send_item(sms_pkg::ACT_DELETE_ALL, 32'hFFFF_FFFF, 1'b1);
        for (k = ACT_UNUSED_FIRST; k <= ACT_UNUSED_LAST; k++)
            send_item(3'(k), 32'h8000_0000, 1'b1);
        send_item(sms_pkg::ACT_INSERT,     32'hAAAA_AAAA, 1'b1);
        send_item(sms_pkg::ACT_INSERT,     32'h5555_5555, 1'b1);
        send_item(sms_pkg::ACT_CLEAR,      32'h5555_5555, 1'b1);
        send_item(sms_pkg::ACT_QUERY,      32'h5555_5555, 1'b1);
        send_item(sms_pkg::ACT_DELETE_ONE, 32'h0000_0000, 1'b1);
        send_item(sms_pkg::ACT_CLEAR,      32'h0000_0000, 1'b1);

        // random: fill/drain/mixed blocks over small value pools
        done = 0;
        blk  = 0;
        hold_wanted = 1'b1;
        while (done < RANDOM_ITEMS) begin
            mode    = (blk == 0) ? MODE_FILL : t_mode'($urandom_range(0, 2));
            blk_len = (blk == 0) ? 100 : $urandom_range(30, 80);
            pool_n  = $urandom_range(1, 12);
            for (k = 0; k < pool_n; k++) pool[k] = fresh_value();
            for (k = 0; k < blk_len && done < RANDOM_ITEMS; k++) begin
                calm = (done >= RANDOM_ITEMS - CALM_ITEMS);
                if ($urandom_range(0, 9) == 0)
                    val = fresh_value();
                else
                    val = pool[$urandom_range(0, pool_n - 1)];
                send_item(pick_action(mode), val, done >= HOLD_ITEMS);
                done++;
            end
            blk++;
        end

        i_valid <= 1'b0;
        k = 0;
        while (mirror.pending() != 0 && k < DRAIN_LIMIT) begin
            @(posedge i_clk);
            k++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.pending() != 0)
            mirror.flag_mismatch("results still outstanding at end of run");
        if (mirror.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
